@@ hdl/gfinv_pkg.sv @@
// shared types for the polynomial inverse pipeline
package gfinv_pkg;

	typedef struct packed {
		logic done;
		logic fail;
	} flags_t;

endpackage

@@ hdl/gfinv_if.sv @@
// valid/ready channel interfaces for operand and result beats
interface gfinv_in_if #(
	parameter int WIDTH = 8
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] operand;

	modport source (output valid, output operand, input ready);
	modport sink (input valid, input operand, output ready);
endinterface

interface gfinv_out_if #(
	parameter int WIDTH = 8
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] inverse;
	logic             no_inverse;

	modport source (output valid, output inverse, output no_inverse, input ready);
	modport sink (input valid, input inverse, input no_inverse, output ready);
endinterface

@@ hdl/gf2m_poly_inverse_core.sv @@
// inverse of a binary polynomial modulo a programmable field polynomial
// one euclid micro step per pipeline stage, registered at the end of each stage
// throughput: one operand beat per cycle through the step pipeline while the result side is not stalled;
// a stalled result beat freezes every stage; nothing is dropped or repeated
// reset clears all stage valid bits and loads the modulus with MOD_RESET
module gf2m_poly_inverse_core #(
	parameter int          WIDTH     = 8,
	parameter int unsigned MOD_RESET = 283
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [WIDTH:0]    cfg_wdata,
	gfinv_in_if.sink          op,
	gfinv_out_if.source       res
);
	localparam int STEPS = 4 * WIDTH + 4;

	logic [WIDTH:0]    mod_q;
	logic              advance;

	logic [WIDTH:0]    ra_s    [1:STEPS];
	logic [WIDTH:0]    rb_s    [1:STEPS];
	logic [WIDTH-1:0]  ca_s    [1:STEPS];
	logic [WIDTH-1:0]  cb_s    [1:STEPS];
	gfinv_pkg::flags_t flags_s [1:STEPS];
	logic [STEPS:1]    valid_s;

	logic [WIDTH:0]    ra_nx    [0:STEPS-1];
	logic [WIDTH:0]    rb_nx    [0:STEPS-1];
	logic [WIDTH-1:0]  ca_nx    [0:STEPS-1];
	logic [WIDTH-1:0]  cb_nx    [0:STEPS-1];
	gfinv_pkg::flags_t flags_nx [0:STEPS-1];

	gfinv_pkg::flags_t flags_init;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= (WIDTH + 1)'(MOD_RESET);
		end else if (cfg_we) begin
			mod_q <= cfg_wdata;
		end
	end

	assign advance    = !valid_s[STEPS] || res.ready;
	assign op.ready   = advance;
	assign flags_init = '0;

	genvar k;
	generate
		for (k = 0; k < STEPS; k++) begin : g_step
			if (k == 0) begin : g_first
				gfinv_step #(.WIDTH(WIDTH)) u_step (
					.ra       (mod_q),
					.rb       ({1'b0, op.operand}),
					.ca       ('0),
					.cb       (WIDTH'(1)),
					.flags    (flags_init),
					.ra_nx    (ra_nx[k]),
					.rb_nx    (rb_nx[k]),
					.ca_nx    (ca_nx[k]),
					.cb_nx    (cb_nx[k]),
					.flags_nx (flags_nx[k])
				);
			end else begin : g_rest
				gfinv_step #(.WIDTH(WIDTH)) u_step (
					.ra       (ra_s[k]),
					.rb       (rb_s[k]),
					.ca       (ca_s[k]),
					.cb       (cb_s[k]),
					.flags    (flags_s[k]),
					.ra_nx    (ra_nx[k]),
					.rb_nx    (rb_nx[k]),
					.ca_nx    (ca_nx[k]),
					.cb_nx    (cb_nx[k]),
					.flags_nx (flags_nx[k])
				);
			end

			always_ff @(posedge clk) begin
				if (advance) begin
					ra_s[k+1]    <= ra_nx[k];
					rb_s[k+1]    <= rb_nx[k];
					ca_s[k+1]    <= ca_nx[k];
					cb_s[k+1]    <= cb_nx[k];
					flags_s[k+1] <= flags_nx[k];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (advance) begin
			valid_s <= {valid_s[STEPS-1:1], op.valid};
		end
	end

	// an item still running at the last stage counts as no inverse
	assign res.valid      = valid_s[STEPS];
	assign res.no_inverse = !flags_s[STEPS].done || flags_s[STEPS].fail;
	assign res.inverse    = res.no_inverse ? '0 : cb_s[STEPS];

endmodule

@@ hdl/gfinv_step.sv @@
// one euclid micro step: shift-xor reduction, swap, or termination check
module gfinv_step #(
	parameter int WIDTH = 8
) (
	input  logic [WIDTH:0]     ra,
	input  logic [WIDTH:0]     rb,
	input  logic [WIDTH-1:0]   ca,
	input  logic [WIDTH-1:0]   cb,
	input  gfinv_pkg::flags_t  flags,
	output logic [WIDTH:0]     ra_nx,
	output logic [WIDTH:0]     rb_nx,
	output logic [WIDTH-1:0]   ca_nx,
	output logic [WIDTH-1:0]   cb_nx,
	output gfinv_pkg::flags_t  flags_nx
);
	localparam int DW = $clog2(WIDTH + 1);

	logic [DW-1:0] dra;
	logic [DW-1:0] drb;
	logic [DW-1:0] sh;
	logic          ra_nz;
	logic          rb_zero;
	logic          rb_one;

	// highest set bit of each remainder
	always_comb begin
		dra = '0;
		drb = '0;
		for (int i = 0; i <= WIDTH; i++) begin
			if (ra[i]) begin
				dra = DW'(i);
			end
			if (rb[i]) begin
				drb = DW'(i);
			end
		end
	end

	assign ra_nz   = |ra;
	assign rb_zero = ~|rb;
	assign rb_one  = (rb == (WIDTH + 1)'(1));
	assign sh      = dra - drb;

	always_comb begin
		ra_nx    = ra;
		rb_nx    = rb;
		ca_nx    = ca;
		cb_nx    = cb;
		flags_nx = flags;
		if (!flags.done) begin
			if (rb_zero) begin
				flags_nx.done = 1'b1;
				flags_nx.fail = 1'b1;
			end else if (rb_one) begin
				flags_nx.done = 1'b1;
				flags_nx.fail = 1'b0;
			end else if (ra_nz && (dra >= drb)) begin
				ra_nx = ra ^ (rb << sh);
				ca_nx = ca ^ (cb << sh);
			end else begin
				// division finished, remainder becomes the new divisor
				ra_nx = rb;
				rb_nx = ra;
				ca_nx = cb;
				cb_nx = ca;
			end
		end
	end

endmodule

@@ hdl/gfinv_chk.sv @@
// port-level checks for the polynomial inverse core, bound to gf2m_poly_inverse_core
module gfinv_chk #(
	parameter int WIDTH = 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             op_valid,
	input logic             op_ready,
	input logic             res_valid,
	input logic             res_ready,
	input logic [WIDTH-1:0] res_inverse,
	input logic             res_no_inverse
);

	// stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_inverse)
			&& $stable(res_no_inverse))
		else $error("result beat changed while stalled");

	// failed beats carry a zero inverse
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_no_inverse |-> res_inverse == '0)
		else $error("no_inverse set with nonzero inverse");

	// empty output never blocks the input side
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> op_ready)
		else $error("operand side blocked with empty output");

	// a stalled output freezes the pipeline
	a_stall_block: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !op_ready)
		else $error("operand accepted while output stalled");

	// after a beat is accepted and a result taken, the input is open or a result waits
	a_accept_keep: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && op_ready && res_valid && res_ready |=> op_ready || res_valid)
		else $error("pipeline lost track of a beat");

endmodule

bind gf2m_poly_inverse_core gfinv_chk #(.WIDTH(WIDTH)) u_gfinv_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.op_valid       (op.valid),
	.op_ready       (op.ready),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_inverse    (res.inverse),
	.res_no_inverse (res.no_inverse)
);
